// File: design/tpa_pkg.sv
// Shared constants and types for the three-phase acceleration profile evaluator.
package tpa_pkg;

    // Default number format: signed or unsigned Q16.16 in 32 bits.
    localparam int DEF_FRAC_BITS   = 16;
    localparam int DEF_VALUE_WIDTH = 32;

    // Profile shape and configuration register file.
    localparam int NUM_PHASES   = 3;
    localparam int NUM_CFG_REGS = 8;
    localparam int CFG_IDX_W    = 3;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_POSITION = 3'd0,
        REG_START_VELOCITY = 3'd1,
        REG_ACCEL_FIRST    = 3'd2,
        REG_ACCEL_MIDDLE   = 3'd3,
        REG_ACCEL_LAST     = 3'd4,
        REG_DUR_FIRST      = 3'd5,
        REG_DUR_MIDDLE     = 3'd6,
        REG_DUR_LAST       = 3'd7
    } cfg_reg_t;

    // Control flags that travel with each sample along the cell chain.
    typedef struct packed {
        logic valid;    // stage holds a live sample
        logic last;     // final sample: velocity and acceleration forced to zero
        logic decided;  // an earlier phase already claimed the active acceleration
        logic sat;      // some position or velocity step was clipped
    } tpa_ctl_t;

endpackage

// File: design/tpa_mulrnd.sv
// Two-stage magnitude-times-time multiplier with round-half-away and saturation.
module tpa_mulrnd
    import tpa_pkg::*;
#(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
    parameter int SHIFT       = DEF_FRAC_BITS
) (
    input  logic                   aclk,
    input  logic                   en,
    input  logic [VALUE_WIDTH:0]   mag,
    input  logic                   neg,
    input  logic [VALUE_WIDTH-1:0] arc,
    output logic [VALUE_WIDTH-1:0] q,
    output logic                   q_neg,
    output logic                   q_sat
);

    localparam int LO_W = (VALUE_WIDTH + 1) / 2;
    localparam int HI_W = VALUE_WIDTH - LO_W;
    localparam int PL_W = VALUE_WIDTH + 1 + LO_W;
    localparam int PH_W = VALUE_WIDTH + 1 + HI_W;
    localparam int PW   = 2 * VALUE_WIDTH + 1;
    localparam int QW   = PW - SHIFT;

    localparam logic [PW-1:0] RND     = PW'(1) << (SHIFT - 1);
    localparam logic [QW-1:0] LIM_NEG = QW'(1) << (VALUE_WIDTH - 1);
    localparam logic [QW-1:0] LIM_POS = LIM_NEG - QW'(1);

    logic [PL_W-1:0]        pl_reg, pl_next;
    logic [PH_W-1:0]        ph_reg, ph_next;
    logic                   neg_reg;
    logic [PW-1:0]          sum_next;
    logic [QW-1:0]          quo, lim;
    logic                   over;
    logic [VALUE_WIDTH-1:0] q_reg, q_next;
    logic                   q_neg_reg, q_sat_reg;

    // First stage: two half-width partial products of the time operand.
    assign pl_next = PL_W'(mag) * PL_W'(arc[LO_W-1:0]);
    assign ph_next = PH_W'(mag) * PH_W'(arc[VALUE_WIDTH-1:LO_W]);

    // Second stage: combine, round to nearest, scale down and clip the magnitude.
    always_comb begin
        sum_next = PW'(pl_reg) + (PW'(ph_reg) << LO_W) + RND;
        quo      = sum_next[PW-1:SHIFT];
        lim      = neg_reg ? LIM_NEG : LIM_POS;
        over     = (quo > lim);
        q_next   = over ? lim[VALUE_WIDTH-1:0] : quo[VALUE_WIDTH-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pl_reg    <= pl_next;
            ph_reg    <= ph_next;
            neg_reg   <= neg;
            q_reg     <= q_next;
            q_neg_reg <= neg_reg;
            q_sat_reg <= over;
        end
    end

    assign q     = q_reg;
    assign q_neg = q_neg_reg;
    assign q_sat = q_sat_reg;

endmodule

// File: design/tpa_cell.sv
// One profile phase: clamps its time slice and advances position and velocity.
module tpa_cell
    import tpa_pkg::*;
#(
    parameter int FRAC_BITS   = DEF_FRAC_BITS,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic [VALUE_WIDTH-1:0] accel,
    input  logic [VALUE_WIDTH-1:0] dur,
    input  tpa_ctl_t               ctl_in,
    input  logic [VALUE_WIDTH-1:0] rest_in,
    input  logic [VALUE_WIDTH-1:0] pos_in,
    input  logic [VALUE_WIDTH-1:0] vel_in,
    input  logic [VALUE_WIDTH-1:0] acc_in,
    output tpa_ctl_t               ctl_out,
    output logic [VALUE_WIDTH-1:0] rest_out,
    output logic [VALUE_WIDTH-1:0] pos_out,
    output logic [VALUE_WIDTH-1:0] vel_out,
    output logic [VALUE_WIDTH-1:0] acc_out
);

    localparam int W = VALUE_WIDTH;

    // Add with clipping to the signed range; the top bit of the result flags a clip.
    function automatic logic [W:0] clip_sum(input logic [W:0] sum);
        logic [W:0] res;
        if (sum[W] != sum[W-1]) begin
            res = {1'b1, sum[W], {(W-1){~sum[W]}}};
        end else begin
            res = {1'b0, sum[W-1:0]};
        end
        return res;
    endfunction

    // Acceleration magnitude, refreshed every cycle from the register file.
    logic [W:0] accel_ext, mag_a_reg;
    logic       neg_a_reg;

    assign accel_ext = {accel[W-1], accel};

    always_ff @(posedge aclk) begin
        neg_a_reg <= accel[W-1];
        mag_a_reg <= accel[W-1] ? (~accel_ext + (W+1)'(1)) : accel_ext;
    end

    // Sideband delay registers, one per internal stage.
    tpa_ctl_t       ctl_pipe_reg  [1:8];
    logic [W-1:0]   rest_pipe_reg [1:8];
    logic [W-1:0]   pos_pipe_reg  [1:8];
    logic [W-1:0]   acc_pipe_reg  [1:8];
    logic [W-1:0]   arc_pipe_reg  [1:6];
    logic [W-1:0]   vel_pipe_reg  [1:4];
    logic [W-1:0]   vn_pipe_reg   [4:8];

    // Stage 1: time slice of this phase and claim of the active acceleration.
    logic         in_slice, take;
    logic [W-1:0] arc_next, rest_next, acc_next;
    tpa_ctl_t     ctl1_next;

    always_comb begin
        in_slice          = (rest_in <= dur);
        arc_next          = in_slice ? rest_in : dur;
        rest_next         = rest_in - arc_next;
        take              = in_slice && !ctl_in.decided;
        acc_next          = take ? accel : acc_in;
        ctl1_next         = ctl_in;
        ctl1_next.decided = ctl_in.decided | take;
    end

    // Stages 2 and 3: velocity step a * arc.
    logic [W-1:0] dv_q;
    logic         dv_neg, dv_sat;

    tpa_mulrnd #(
        .VALUE_WIDTH(W),
        .SHIFT      (FRAC_BITS)
    ) u_mul_dv (
        .aclk (aclk),
        .en   (en),
        .mag  (mag_a_reg),
        .neg  (neg_a_reg),
        .arc  (arc_pipe_reg[1]),
        .q    (dv_q),
        .q_neg(dv_neg),
        .q_sat(dv_sat)
    );

    // Stage 4: new velocity, clipped.
    logic [W:0] sum4, clip4;

    always_comb begin
        if (dv_neg) begin
            sum4 = {vel_pipe_reg[3][W-1], vel_pipe_reg[3]} - {1'b0, dv_q};
        end else begin
            sum4 = {vel_pipe_reg[3][W-1], vel_pipe_reg[3]} + {1'b0, dv_q};
        end
        clip4 = clip_sum(sum4);
    end

    // Stage 5: sum of old and new velocity; stage 6: its magnitude.
    logic [W:0] s_reg, s_next, ms_reg, ms_next;
    logic       negs_reg;

    assign s_next  = {vel_pipe_reg[4][W-1], vel_pipe_reg[4]}
                   + {vn_pipe_reg[4][W-1], vn_pipe_reg[4]};
    assign ms_next = s_reg[W] ? (~s_reg + (W+1)'(1)) : s_reg;

    // Stages 7 and 8: position step arc * (v + v_new) / 2.
    logic [W-1:0] dp_q;
    logic         dp_neg, dp_sat;

    tpa_mulrnd #(
        .VALUE_WIDTH(W),
        .SHIFT      (FRAC_BITS + 1)
    ) u_mul_dp (
        .aclk (aclk),
        .en   (en),
        .mag  (ms_reg),
        .neg  (negs_reg),
        .arc  (arc_pipe_reg[6]),
        .q    (dp_q),
        .q_neg(dp_neg),
        .q_sat(dp_sat)
    );

    // Stage 9: new position, clipped.
    logic [W:0] sum9, clip9;

    always_comb begin
        if (dp_neg) begin
            sum9 = {pos_pipe_reg[8][W-1], pos_pipe_reg[8]} - {1'b0, dp_q};
        end else begin
            sum9 = {pos_pipe_reg[8][W-1], pos_pipe_reg[8]} + {1'b0, dp_q};
        end
        clip9 = clip_sum(sum9);
    end

    // Payload shift through the stages.
    logic [W-1:0] pos_out_reg, vel_out_reg, rest_out_reg, acc_out_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            rest_pipe_reg[1] <= rest_next;
            pos_pipe_reg[1]  <= pos_in;
            acc_pipe_reg[1]  <= acc_next;
            arc_pipe_reg[1]  <= arc_next;
            vel_pipe_reg[1]  <= vel_in;
            for (int k = 2; k <= 8; k++) begin
                rest_pipe_reg[k] <= rest_pipe_reg[k-1];
                pos_pipe_reg[k]  <= pos_pipe_reg[k-1];
                acc_pipe_reg[k]  <= acc_pipe_reg[k-1];
            end
            for (int k = 2; k <= 6; k++) begin
                arc_pipe_reg[k] <= arc_pipe_reg[k-1];
            end
            for (int k = 2; k <= 4; k++) begin
                vel_pipe_reg[k] <= vel_pipe_reg[k-1];
            end
            vn_pipe_reg[4] <= clip4[W-1:0];
            for (int k = 5; k <= 8; k++) begin
                vn_pipe_reg[k] <= vn_pipe_reg[k-1];
            end
            s_reg        <= s_next;
            ms_reg       <= ms_next;
            negs_reg     <= s_reg[W];
            pos_out_reg  <= clip9[W-1:0];
            vel_out_reg  <= vn_pipe_reg[8];
            rest_out_reg <= rest_pipe_reg[8];
            acc_out_reg  <= acc_pipe_reg[8];
        end
    end

    // Control flags, with clip reports merged where the adders sit.
    tpa_ctl_t ctl_out_reg;
    tpa_ctl_t ctl4_next, ctl_end_next;

    always_comb begin
        ctl4_next        = ctl_pipe_reg[3];
        ctl4_next.sat    = ctl_pipe_reg[3].sat | dv_sat | clip4[W];
        ctl_end_next     = ctl_pipe_reg[8];
        ctl_end_next.sat = ctl_pipe_reg[8].sat | dp_sat | clip9[W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 1; k <= 8; k++) begin
                ctl_pipe_reg[k] <= '0;
            end
            ctl_out_reg <= '0;
        end else if (en) begin
            ctl_pipe_reg[1] <= ctl1_next;
            for (int k = 2; k <= 3; k++) begin
                ctl_pipe_reg[k] <= ctl_pipe_reg[k-1];
            end
            ctl_pipe_reg[4] <= ctl4_next;
            for (int k = 5; k <= 8; k++) begin
                ctl_pipe_reg[k] <= ctl_pipe_reg[k-1];
            end
            ctl_out_reg <= ctl_end_next;
        end
    end

    assign ctl_out  = ctl_out_reg;
    assign rest_out = rest_out_reg;
    assign pos_out  = pos_out_reg;
    assign vel_out  = vel_out_reg;
    assign acc_out  = acc_out_reg;

endmodule

// File: design/three_phase_accel_profile_eval.sv
// Top level of the three-phase constant-acceleration profile evaluator, one axis.
//
// Usage: write the eight profile registers through the cfg_* port while the
// block is idle, then stream sample times on the s_axis channel. Each input
// beat carries a sample time in tdata and the final-sample flag in tlast.
// Each output beat carries position, velocity and acceleration in tdata and
// the saturation flag in tuser. Use one instance per axis.
//
// The datapath is a chain of three phase cells, nine register stages each,
// followed by an output register. While the output is not stalled, the chain
// takes one beat per cycle, so the sustained rate is one sample per clock.
//
// When the receiver stalls, one further result is caught in a skid register
// and s_axis_tready drops in the next cycle; the whole chain then holds
// until the output drains. Reset clears all valid flags and the profile
// registers to zero; the block is ready in the first cycle after reset.
module three_phase_accel_profile_eval
    import tpa_pkg::*;
#(
    parameter int FRAC_BITS   = DEF_FRAC_BITS,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // Configuration write port.
    input  logic                                    cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]                    cfg_addr,
    input  logic [VALUE_WIDTH-1:0]                  cfg_wr_data,
    // Sample beats in.
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // tdata, from bit 0: sample_time, then zero fill.
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0]        s_axis_tdata,
    // tlast: final_sample.
    input  logic                                    s_axis_tlast,
    // Result beats out.
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // tdata, from bit 0: position, velocity, acceleration, then zero fill.
    output logic [((3*VALUE_WIDTH+7)/8)*8-1:0]      m_axis_tdata,
    // tuser: saturated.
    output logic                                    m_axis_tuser
);

    localparam int W      = VALUE_WIDTH;
    localparam int MDATA_W = ((3 * W + 7) / 8) * 8;
    localparam int RES_W  = 3 * W + 1;

    // Profile registers.
    logic [W-1:0] start_position_reg, start_velocity_reg;
    logic [W-1:0] accel_first_reg, accel_middle_reg, accel_last_reg;
    logic [W-1:0] dur_first_reg, dur_middle_reg, dur_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_position_reg <= '0;
            start_velocity_reg <= '0;
            accel_first_reg    <= '0;
            accel_middle_reg   <= '0;
            accel_last_reg     <= '0;
            dur_first_reg      <= '0;
            dur_middle_reg     <= '0;
            dur_last_reg       <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_START_POSITION: start_position_reg <= cfg_wr_data;
                REG_START_VELOCITY: start_velocity_reg <= cfg_wr_data;
                REG_ACCEL_FIRST:    accel_first_reg    <= cfg_wr_data;
                REG_ACCEL_MIDDLE:   accel_middle_reg   <= cfg_wr_data;
                REG_ACCEL_LAST:     accel_last_reg     <= cfg_wr_data;
                REG_DUR_FIRST:      dur_first_reg      <= cfg_wr_data;
                REG_DUR_MIDDLE:     dur_middle_reg     <= cfg_wr_data;
                REG_DUR_LAST:       dur_last_reg       <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Per-phase settings handed to the cells.
    logic [W-1:0] accel_arr [NUM_PHASES];
    logic [W-1:0] dur_arr   [NUM_PHASES];

    assign accel_arr[0] = accel_first_reg;
    assign accel_arr[1] = accel_middle_reg;
    assign accel_arr[2] = accel_last_reg;
    assign dur_arr[0]   = dur_first_reg;
    assign dur_arr[1]   = dur_middle_reg;
    assign dur_arr[2]   = dur_last_reg;

    // Chain links between cells; link 0 is the incoming beat.
    tpa_ctl_t     ctl_chain  [NUM_PHASES+1];
    logic [W-1:0] rest_chain [NUM_PHASES+1];
    logic [W-1:0] pos_chain  [NUM_PHASES+1];
    logic [W-1:0] vel_chain  [NUM_PHASES+1];
    logic [W-1:0] acc_chain  [NUM_PHASES+1];
    logic         en;

    always_comb begin
        ctl_chain[0]         = '0;
        ctl_chain[0].valid   = s_axis_tvalid;
        ctl_chain[0].last    = s_axis_tlast;
        rest_chain[0]        = s_axis_tdata[W-1:0];
        pos_chain[0]         = start_position_reg;
        vel_chain[0]         = start_velocity_reg;
        acc_chain[0]         = '0;
    end

    for (genvar g = 0; g < NUM_PHASES; g++) begin : g_cell
        tpa_cell #(
            .FRAC_BITS  (FRAC_BITS),
            .VALUE_WIDTH(W)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .accel   (accel_arr[g]),
            .dur     (dur_arr[g]),
            .ctl_in  (ctl_chain[g]),
            .rest_in (rest_chain[g]),
            .pos_in  (pos_chain[g]),
            .vel_in  (vel_chain[g]),
            .acc_in  (acc_chain[g]),
            .ctl_out (ctl_chain[g+1]),
            .rest_out(rest_chain[g+1]),
            .pos_out (pos_chain[g+1]),
            .vel_out (vel_chain[g+1]),
            .acc_out (acc_chain[g+1])
        );
    end

    // Final shaping: default to the last phase, zero the rates on the final sample.
    tpa_ctl_t     ctl_end;
    logic [W-1:0] acc_fin, vel_fin;
    logic [RES_W-1:0] res_next;

    always_comb begin
        ctl_end = ctl_chain[NUM_PHASES];
        acc_fin = ctl_end.decided ? acc_chain[NUM_PHASES] : accel_last_reg;
        vel_fin = vel_chain[NUM_PHASES];
        if (ctl_end.last) begin
            acc_fin = '0;
            vel_fin = '0;
        end
        res_next = {ctl_end.sat, acc_fin, vel_fin, pos_chain[NUM_PHASES]};
    end

    // Output register with one skid entry; the chain advances while the skid is empty.
    logic             out_valid_reg, skid_valid_reg;
    logic [RES_W-1:0] out_data_reg, skid_data_reg;
    logic             out_free, load_chain;

    assign en         = !skid_valid_reg;
    assign out_free   = !out_valid_reg || m_axis_tready;
    assign load_chain = en && ctl_end.valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= load_chain;
            end
        end else if (load_chain) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : res_next;
        end else if (load_chain) begin
            skid_data_reg <= res_next;
        end
    end

    assign s_axis_tready = en;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = MDATA_W'(out_data_reg[3*W-1:0]);
    assign m_axis_tuser  = out_data_reg[3*W];

endmodule

// File: design/tpa_checker.sv
// Port-level assertions for the profile evaluator, bound to the top level.
module tpa_checker #(
    parameter int VALUE_WIDTH = 32
) (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [((3*VALUE_WIDTH+7)/8)*8-1:0]  m_axis_tdata,
    input logic                                m_axis_tuser
);

    // A stalled result beat stays and keeps its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // Reset empties the output stage.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // The input side only closes after a stalled result.
    a_ready_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready))
        else $error("input ready fell without an output stall");

    // While the input side is closed, a result is waiting at the output.
    a_closed_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input closed with an empty output");

    // An accepted input beat with no result waiting keeps the input side open in the next cycle.
    a_accept_open: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> s_axis_tready)
        else $error("input closed with no result waiting");

endmodule

bind three_phase_accel_profile_eval tpa_checker #(
    .VALUE_WIDTH(VALUE_WIDTH)
) u_tpa_checker (.*);
